### design/xkwd_pkg.sv
// ----------------------------------------------------------------------------
// xkwd_pkg
// Shared constants, types and key-store access struct for the keyed XOR word
// descrambler.
// ----------------------------------------------------------------------------
package xkwd_pkg;

  localparam int WORD_W        = 32;
  localparam int KEY_WORDS     = 1024;
  localparam int SECURE_WORDS  = 512;
  localparam int STRIDE        = 64;
  localparam int CHECK_WORDS   = 128;
  localparam int POS_CAP       = SECURE_WORDS + CHECK_WORDS;
  localparam int MIX_ROUNDS    = 6;
  localparam logic [WORD_W-1:0] MIX_DELTA = 32'h9e37_79b9;

  localparam int NUM_KEY_PARTS = 4;
  localparam int CFG_IW        = 3;

  localparam int KEY_AW = $clog2(KEY_WORDS);
  localparam int IDX_W  = $clog2(POS_CAP + 1);
  localparam int PH_W   = (STRIDE > 1) ? $clog2(STRIDE) : 1;
  localparam int RND_W  = $clog2(MIX_ROUNDS);

  localparam logic [KEY_AW-1:0] KEY_LAST = KEY_AW'(KEY_WORDS - 1);

  typedef logic [WORD_W-1:0] word_t;
  typedef logic [KEY_AW-1:0] key_addr_t;
  typedef logic [NUM_KEY_PARTS-1:0][WORD_W-1:0] key_parts_t;

  // one read and one write port of the key store
  typedef struct packed {
    logic      rd_en;
    key_addr_t rd_addr;
    logic      wr_en;
    key_addr_t wr_addr;
    word_t     wr_data;
  } mem_req_t;

endpackage

### design/xkwd_key_ram.sv
// ----------------------------------------------------------------------------
// xkwd_key_ram
// Expanded key store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module xkwd_key_ram
  import xkwd_pkg::*;
(
  input  logic     clk,
  input  mem_req_t req,
  output word_t    rdata
);

  word_t mem [KEY_WORDS];
  word_t rdata_r;

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_addr] <= req.wr_data;
    end
    if (req.rd_en) begin
      rdata_r <= mem[req.rd_addr];
    end
  end

  assign rdata = rdata_r;

endmodule

### design/xkwd_key_mixer.sv
// ----------------------------------------------------------------------------
// xkwd_key_mixer
// Key expansion engine: six in-place XXTEA-style rounds over the key store,
// each word in turn: mix terms, then add and write back.
// ----------------------------------------------------------------------------
module xkwd_key_mixer
  import xkwd_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       start,
  input  key_parts_t key_parts,
  input  word_t      rdata,
  output mem_req_t   req,
  output logic       done
);

  typedef enum logic [2:0] {
    M_IDLE,
    M_LD0,
    M_LD1,
    M_LD2,
    M_MIXA,
    M_MIXB
  } mix_state_t;

  mix_state_t state_r, state_nxt;
  key_addr_t  p_r, p_nxt;
  logic [RND_W-1:0] rnd_r, rnd_nxt;
  word_t sum_r, sum_nxt;
  word_t z_r, z_nxt;
  word_t cur_r, cur_nxt;
  word_t y_r, y_nxt;
  word_t first_r, first_nxt;
  word_t a_r, a_nxt;
  word_t b_r, b_nxt;
  logic  done_nxt;
  logic  done_r;

  word_t y;
  word_t k;
  word_t new_word;
  logic [KEY_AW:0] p_plus2;
  key_addr_t rd_next;

  assign y = (p_r == KEY_LAST) ? first_r : rdata;
  assign k = key_parts[p_r[1:0] ^ sum_r[3:2]];
  assign new_word = cur_r + (a_r ^ b_r);

  // read ahead two words, wrapping at the end of the store
  always_comb begin
    p_plus2 = {1'b0, p_r} + (KEY_AW + 1)'(2);
    if (p_plus2 >= (KEY_AW + 1)'(KEY_WORDS)) begin
      rd_next = KEY_AW'(p_plus2 - (KEY_AW + 1)'(KEY_WORDS));
    end else begin
      rd_next = KEY_AW'(p_plus2);
    end
  end

  always_comb begin
    state_nxt = state_r;
    p_nxt     = p_r;
    rnd_nxt   = rnd_r;
    sum_nxt   = sum_r;
    z_nxt     = z_r;
    cur_nxt   = cur_r;
    y_nxt     = y_r;
    first_nxt = first_r;
    a_nxt     = a_r;
    b_nxt     = b_r;
    done_nxt  = 1'b0;
    req       = '0;

    case (state_r)
      M_IDLE: begin
        if (start) begin
          state_nxt = M_LD0;
        end
      end
      M_LD0: begin
        req.rd_en   = 1'b1;
        req.rd_addr = '0;
        state_nxt   = M_LD1;
      end
      M_LD1: begin
        req.rd_en   = 1'b1;
        req.rd_addr = KEY_LAST;
        cur_nxt     = rdata;
        state_nxt   = M_LD2;
      end
      M_LD2: begin
        req.rd_en   = 1'b1;
        req.rd_addr = KEY_AW'(1);
        z_nxt       = rdata;
        sum_nxt     = MIX_DELTA;
        p_nxt       = '0;
        rnd_nxt     = '0;
        state_nxt   = M_MIXA;
      end
      M_MIXA: begin
        a_nxt = ((z_r >> 5) ^ (y << 2)) + ((y >> 3) ^ (z_r << 4));
        b_nxt = (sum_r ^ y) + (k ^ z_r);
        y_nxt = y;
        state_nxt = M_MIXB;
      end
      M_MIXB: begin
        req.wr_en   = 1'b1;
        req.wr_addr = p_r;
        req.wr_data = new_word;
        req.rd_en   = 1'b1;
        req.rd_addr = rd_next;
        z_nxt       = new_word;
        cur_nxt     = y_r;
        if (p_r == '0) begin
          first_nxt = new_word;
        end
        state_nxt = M_MIXA;
        if (p_r == KEY_LAST) begin
          p_nxt = '0;
          if (rnd_r == RND_W'(MIX_ROUNDS - 1)) begin
            done_nxt  = 1'b1;
            state_nxt = M_IDLE;
          end else begin
            rnd_nxt = rnd_r + RND_W'(1);
            sum_nxt = sum_r + MIX_DELTA;
          end
        end else begin
          p_nxt = p_r + KEY_AW'(1);
        end
      end
      default: begin
        state_nxt = M_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= M_IDLE;
      done_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      done_r  <= done_nxt;
    end
    p_r     <= p_nxt;
    rnd_r   <= rnd_nxt;
    sum_r   <= sum_nxt;
    z_r     <= z_nxt;
    cur_r   <= cur_nxt;
    y_r     <= y_nxt;
    first_r <= first_nxt;
    a_r     <= a_nxt;
    b_r     <= b_nxt;
  end

  // done is combinational on the final write-back
  assign done = done_nxt;

  // -- assertions --
  a_done_single: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> !done_nxt)
    else $error("mixer done asserted on consecutive cycles");

  a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
    start |-> state_r == M_IDLE)
    else $error("expansion started while mixer busy");

  a_write_phase: assert property (@(posedge clk) disable iff (!rst_n)
    req.wr_en |-> state_r == M_MIXB)
    else $error("key store write outside write-back phase");

endmodule

### design/xkwd_word_ctrl.sv
// ----------------------------------------------------------------------------
// xkwd_word_ctrl
// Word sequencer: handshake, payload position, stride phase, key pointer,
// checksum, key store clearing after reset and key store port selection.
// ----------------------------------------------------------------------------
module xkwd_word_ctrl
  import xkwd_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  word_t    in_data_word,
  input  logic     in_first_word,
  output logic     out_valid,
  input  logic     out_ready,
  output word_t    out_out_word,
  output logic     out_was_decoded,
  output word_t    out_check_value,
  input  logic     key_valid,
  output logic     mix_start,
  input  logic     mix_done,
  input  mem_req_t mix_req,
  output mem_req_t mem_req,
  input  word_t    mem_rdata
);

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_EXPAND,
    S_READ,
    S_FIN
  } ctrl_state_t;

  ctrl_state_t state_r, state_nxt;
  key_addr_t   clr_r, clr_nxt;
  logic [IDX_W-1:0] idx_r, idx_nxt;
  logic [PH_W-1:0]  ph_r, ph_nxt;
  key_addr_t   ptr_r, ptr_nxt;
  word_t       chk_r, chk_nxt;
  word_t       data_r, data_nxt;
  logic        dec_r, dec_nxt;
  logic        in_chk_r, in_chk_nxt;
  key_addr_t   rd_ptr_r, rd_ptr_nxt;
  logic        out_valid_r, out_valid_nxt;
  word_t       out_word_r, out_word_nxt;
  logic        out_dec_r, out_dec_nxt;
  word_t       out_chk_r, out_chk_nxt;

  logic             accept;
  logic [IDX_W-1:0] idx_eff;
  logic [PH_W-1:0]  ph_eff;
  key_addr_t        ptr_eff;
  logic             secure;
  logic             decode;
  logic             slot_free;
  word_t            result;

  assign in_ready  = (state_r == S_IDLE);
  assign accept    = in_valid && in_ready;
  assign slot_free = !out_valid_r || out_ready;

  // a first word restarts the payload before it is handled
  assign idx_eff = in_first_word ? '0 : idx_r;
  assign ph_eff  = in_first_word ? '0 : ph_r;
  assign ptr_eff = in_first_word ? '0 : ptr_r;
  assign secure  = idx_eff >= IDX_W'(SECURE_WORDS);
  assign decode  = !secure || (ph_eff == '0);

  assign mix_start = accept && decode && !key_valid;
  assign result    = dec_r ? (data_r ^ mem_rdata) : data_r;

  always_comb begin
    state_nxt     = state_r;
    clr_nxt       = clr_r;
    idx_nxt       = idx_r;
    ph_nxt        = ph_r;
    ptr_nxt       = ptr_r;
    chk_nxt       = chk_r;
    data_nxt      = data_r;
    dec_nxt       = dec_r;
    in_chk_nxt    = in_chk_r;
    rd_ptr_nxt    = rd_ptr_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_word_nxt  = out_word_r;
    out_dec_nxt   = out_dec_r;
    out_chk_nxt   = out_chk_r;
    mem_req       = '0;

    case (state_r)
      S_CLEAR: begin
        mem_req.wr_en   = 1'b1;
        mem_req.wr_addr = clr_r;
        mem_req.wr_data = '0;
        clr_nxt         = clr_r + KEY_AW'(1);
        if (clr_r == KEY_LAST) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (accept) begin
          data_nxt   = in_data_word;
          dec_nxt    = decode;
          in_chk_nxt = idx_eff < IDX_W'(CHECK_WORDS);
          rd_ptr_nxt = ptr_eff;
          if (in_first_word) begin
            chk_nxt = '0;
          end
          if (decode) begin
            ptr_nxt = (ptr_eff == KEY_LAST) ? '0 : ptr_eff + KEY_AW'(1);
          end else begin
            ptr_nxt = ptr_eff;
          end
          if (secure) begin
            ph_nxt = (ph_eff == PH_W'(STRIDE - 1)) ? '0 : ph_eff + PH_W'(1);
          end else begin
            ph_nxt = ph_eff;
          end
          idx_nxt = (idx_eff < IDX_W'(POS_CAP)) ? idx_eff + IDX_W'(1) : idx_eff;
          if (!decode) begin
            state_nxt = S_FIN;
          end else if (!key_valid) begin
            state_nxt = S_EXPAND;
          end else begin
            state_nxt = S_READ;
          end
        end
      end
      S_EXPAND: begin
        mem_req = mix_req;
        if (mix_done) begin
          state_nxt = S_READ;
        end
      end
      S_READ: begin
        mem_req.rd_en   = 1'b1;
        mem_req.rd_addr = rd_ptr_r;
        state_nxt       = S_FIN;
      end
      S_FIN: begin
        if (slot_free) begin
          if (in_chk_r) begin
            chk_nxt = chk_r ^ result;
          end
          out_valid_nxt = 1'b1;
          out_word_nxt  = result;
          out_dec_nxt   = dec_r;
          out_chk_nxt   = in_chk_r ? (chk_r ^ result) : chk_r;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_r       <= '0;
      idx_r       <= '0;
      ph_r        <= '0;
      ptr_r       <= '0;
      chk_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      idx_r       <= idx_nxt;
      ph_r        <= ph_nxt;
      ptr_r       <= ptr_nxt;
      chk_r       <= chk_nxt;
      out_valid_r <= out_valid_nxt;
    end
    data_r     <= data_nxt;
    dec_r      <= dec_nxt;
    in_chk_r   <= in_chk_nxt;
    rd_ptr_r   <= rd_ptr_nxt;
    out_word_r <= out_word_nxt;
    out_dec_r  <= out_dec_nxt;
    out_chk_r  <= out_chk_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_out_word    = out_word_r;
  assign out_was_decoded = out_dec_r;
  assign out_check_value = out_chk_r;

  // -- assertions --
  a_wr_owner: assert property (@(posedge clk) disable iff (!rst_n)
    mem_req.wr_en |-> (state_r == S_CLEAR || state_r == S_EXPAND))
    else $error("key store written outside clear or expansion");

  a_done_expand: assert property (@(posedge clk) disable iff (!rst_n)
    mix_done |-> state_r == S_EXPAND)
    else $error("expansion finished while not waiting for it");

  a_read_then_fin: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_READ |=> state_r == S_FIN)
    else $error("key read not followed by finish");

  a_idx_cap: assert property (@(posedge clk) disable iff (!rst_n)
    idx_r <= IDX_W'(POS_CAP))
    else $error("payload position past saturation");

  a_fin_keyvalid: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_READ) |-> key_valid)
    else $error("key read under invalid key");

endmodule

### design/xxtea_keyed_xor_word_descrambler.sv
// ----------------------------------------------------------------------------
// xxtea_keyed_xor_word_descrambler
// Descrambles 32-bit payload words with a 1024-word expanded key store.
// ----------------------------------------------------------------------------
// After reset the block zeroes the key store, one entry a cycle, and takes no
// word until that is done. Key writes on the cfg port take effect at once but
// belong between words, with no word in flight. A word that is XORed goes
// through accept, key store read and result; a word that passes through
// unchanged skips the read. The first XORed word after a key change also
// waits for the key expansion: a setup that reads the first, last and second
// entries, then for each entry of each of the six rounds a mix step and an
// add-and-write-back step into the same memory. A result waits in the output
// register while the next word is taken.
// ----------------------------------------------------------------------------
module xxtea_keyed_xor_word_descrambler
  import xkwd_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_we,
  input  logic [CFG_IW-1:0] cfg_index,
  input  word_t             cfg_wdata,
  input  logic              in_valid,
  output logic              in_ready,
  input  word_t             in_data_word,
  input  logic              in_first_word,
  output logic              out_valid,
  input  logic              out_ready,
  output word_t             out_out_word,
  output logic              out_was_decoded,
  output word_t             out_check_value
);

  key_parts_t key_parts_r;
  logic       key_valid_r;
  logic       mix_start;
  logic       mix_done;
  mem_req_t   mix_req;
  mem_req_t   mem_req;
  word_t      mem_rdata;
  logic       cfg_hit;
  logic [1:0] cfg_sel;

  assign cfg_hit = cfg_we && (cfg_index < CFG_IW'(NUM_KEY_PARTS));
  assign cfg_sel = cfg_index[1:0];

  // a write of an unchanged value keeps the expanded key
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_parts_r <= '0;
      key_valid_r <= 1'b0;
    end else begin
      if (cfg_hit && (key_parts_r[cfg_sel] != cfg_wdata)) begin
        key_parts_r[cfg_sel] <= cfg_wdata;
        key_valid_r          <= 1'b0;
      end else if (mix_done) begin
        key_valid_r <= 1'b1;
      end
    end
  end

  xkwd_key_ram u_ram (
    .clk   (clk),
    .req   (mem_req),
    .rdata (mem_rdata)
  );

  xkwd_key_mixer u_mixer (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (mix_start),
    .key_parts (key_parts_r),
    .rdata     (mem_rdata),
    .req       (mix_req),
    .done      (mix_done)
  );

  xkwd_word_ctrl u_ctrl (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_data_word    (in_data_word),
    .in_first_word   (in_first_word),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_out_word    (out_out_word),
    .out_was_decoded (out_was_decoded),
    .out_check_value (out_check_value),
    .key_valid       (key_valid_r),
    .mix_start       (mix_start),
    .mix_done        (mix_done),
    .mix_req         (mix_req),
    .mem_req         (mem_req),
    .mem_rdata       (mem_rdata)
  );

endmodule
